// ----- hdl/cwt_pkg.sv -----
package cwt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int CODE_W          = 32;
    localparam int SLOT_W          = 8;
    localparam int MODE_W          = 2;
    localparam int ENTRY_COUNT_W   = 5;
    localparam int KEY_CHARS       = 8;
    localparam int CODE_CHARS      = 4;
    localparam int IN_TDATA_W      = 80;
    localparam int OUT_TDATA_W     = 40;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7a;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef struct packed {
        logic load;
        logic idx_zero;
        logic idx_slot;
        logic idx_inc;
        logic rd_en;
        logic rd_next;
        logic wr_shift;
        logic wr_add;
        logic cnt_inc;
        logic cnt_dec;
        logic res_load;
        logic res_success;
        logic res_changed;
        logic res_take;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  code_zero;
        logic  slot_ok;
        logic  full;
        logic  scan_end;
        logic  shift_end;
        logic  match;
        logic  out_free;
    } t_stat;

    // skip leading spaces, take up to four characters (stopping at a space or NUL), fold to upper case
    function automatic logic [CODE_W-1:0] f_normalize(input logic [2*CODE_W-1:0] key);
        logic [CODE_W-1:0] code;
        logic              lead;
        logic              stop;
        logic [2:0]        taken;
        logic [7:0]        c;
        code  = '0;
        lead  = 1'b1;
        stop  = 1'b0;
        taken = '0;
        for (int p = 0; p < KEY_CHARS; p++) begin
            c = key[p*8 +: 8];
            if (!(lead && c == SPACE_CHAR)) begin
                lead = 1'b0;
                if (!stop && taken < 3'(CODE_CHARS)) begin
                    if (c == NUL_CHAR || c == SPACE_CHAR) begin
                        stop = 1'b1;
                    end else begin
                        if (c >= LOWER_A && c <= LOWER_Z) begin
                            c = c - CASE_DIFF;
                        end
                        code  = code | (CODE_W'(c) << {taken[1:0], 3'b000});
                        taken = taken + 3'd1;
                    end
                end
            end
        end
        return code;
    endfunction

endpackage

// ----- hdl/cwt_ctrl.sv -----
module cwt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  cwt_pkg::t_stat i_stat,
    output cwt_pkg::t_cmd  o_cmd
);
    import cwt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_succ, n_succ;
    logic   r_chg, n_chg;
    logic   r_take, n_take;

    always_comb begin
        n_state    = r_state;
        n_succ     = r_succ;
        n_chg      = r_chg;
        n_take     = r_take;
        o_cmd      = '0;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_succ     = 1'b0;
                    n_chg      = 1'b0;
                    n_take     = 1'b0;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_stat.mode)
                    MODE_LOOKUP: begin
                        if (i_stat.code_zero) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = ST_SCAN_RD;
                        end
                    end
                    MODE_ADD: begin
                        if (i_stat.code_zero || i_stat.full) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = ST_SCAN_RD;
                        end
                    end
                    MODE_REMOVE: begin
                        if (!i_stat.slot_ok) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.idx_slot = 1'b1;
                            n_state        = ST_SHIFT_RD;
                        end
                    end
                    default: begin
                        if (!i_stat.slot_ok) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.idx_slot = 1'b1;
                            n_state        = ST_READ_RD;
                        end
                    end
                endcase
            end
            ST_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    // not found: append on add
                    if (i_stat.mode == MODE_ADD) begin
                        o_cmd.wr_add  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        n_succ        = 1'b1;
                        n_chg         = 1'b1;
                    end
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_stat.match) begin
                    n_succ  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (i_stat.shift_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_succ        = 1'b1;
                    n_chg         = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = ST_SHIFT_RD;
            end
            ST_READ_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                n_succ  = 1'b1;
                n_take  = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.res_success = r_succ;
        o_cmd.res_changed = r_chg;
        o_cmd.res_take    = r_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_succ  <= 1'b0;
            r_chg   <= 1'b0;
            r_take  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_succ  <= n_succ;
            r_chg   <= n_chg;
            r_take  <= n_take;
        end
    end

endmodule

// ----- hdl/cwt_dpath.sv -----
module cwt_dpath #(
    parameter int TABLE_DEPTH = cwt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [cwt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [cwt_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  cwt_pkg::t_cmd                      i_cmd,
    output cwt_pkg::t_stat                     o_stat
);
    import cwt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CODE_W-1:0]      r_table [TABLE_DEPTH];
    t_mode                  r_mode;
    logic [SLOT_W-1:0]      r_slot;
    logic [CODE_W-1:0]      r_code;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_count;
    logic [CODE_W-1:0]      r_rdata;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0] w_idx_plus;
    logic [CNT_W:0]   w_idx_plus_wide;
    logic [IDX_W-1:0] w_rd_addr;

    assign w_idx_plus      = r_idx + CNT_W'(1);
    assign w_idx_plus_wide = (CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1);
    assign w_rd_addr       = i_cmd.rd_next ? w_idx_plus[IDX_W-1:0] : r_idx[IDX_W-1:0];

    assign o_stat.mode      = r_mode;
    assign o_stat.code_zero = (r_code == '0);
    assign o_stat.slot_ok   = (r_slot < SLOT_W'(r_count));
    assign o_stat.full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_stat.scan_end  = (r_idx >= r_count);
    assign o_stat.shift_end = (w_idx_plus_wide >= (CNT_W + 1)'(r_count));
    assign o_stat.match     = (r_rdata == r_code);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // entry table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift) begin
            r_table[r_idx[IDX_W-1:0]] <= r_rdata;
        end else if (i_cmd.wr_add) begin
            r_table[r_count[IDX_W-1:0]] <= r_code;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_table[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_s_tdata[MODE_W-1:0]);
            r_slot <= i_s_tdata[MODE_W +: SLOT_W];
            r_code <= f_normalize(i_s_tdata[MODE_W + SLOT_W +: 2*CODE_W]);
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_slot) begin
            r_idx <= CNT_W'(r_slot);
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_plus;
        end
        if (i_cmd.res_load) begin
            r_out_data <= OUT_TDATA_W'({ENTRY_COUNT_W'(r_count),
                                        (i_cmd.res_take ? r_rdata : CODE_W'(0)),
                                        i_cmd.res_changed,
                                        i_cmd.res_success});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/code_watchlist_table_unit.sv -----
// lookup and add scan the table entry by entry, remove shifts the later entries down,
//   read fetches one entry, and rejected requests go straight to the result
// one word in work at a time, set by the single-port table scan and shift;
//   ready for the next word in the cycle after the result loads
// a finished word waits in the output register while the next word is taken
// reset: synchronous active low, clears the count (table empty) and output valid
module code_watchlist_table_unit #(
    parameter int TABLE_DEPTH = cwt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // mode[1:0], slot[9:2], text_low[41:10], text_high[73:42], zero pad
    input  logic [cwt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // success[0], changed[1], entry_code[33:2], entry_count[38:34], zero pad
    output logic [cwt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import cwt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cwt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

// ----- hdl/cwt_checker.sv -----
module cwt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_tready,
    input logic                            i_m_tvalid,
    input logic [cwt_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import cwt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word changed while stalled");

    a_changed_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[1] |-> i_m_tdata[0])
        else $error("changed without success");

    a_entry_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tdata[33:2] != '0) |-> i_m_tdata[0] && !i_m_tdata[1])
        else $error("entry code outside a successful read");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind code_watchlist_table_unit cwt_checker u_cwt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tdata  (o_m_tdata)
);
